// ===== src/rstd_pkg.sv =====
package rstd_pkg;

	localparam int unsigned TABLE_DEPTH = 64;
	localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
	localparam int unsigned LIT_DIST_W  = 10;
	localparam int unsigned LIT_ALIGN_W = 6;
	localparam int unsigned MAT_W       = 8;
	localparam int unsigned ALIGN_W     = 8;
	localparam int unsigned DIST_W      = 12;
	localparam int unsigned ENTRY_W     = LIT_DIST_W + ALIGN_W + MAT_W;
	localparam int unsigned DDIST_W     = 9;
	localparam int unsigned DALIGN_W    = 4;

	// first byte of the four-byte literal
	localparam logic [7:0] CODE_LONG = 8'hFF;

	// two-bit class of the first byte of a code
	localparam logic [1:0] CLS_DIRECT = 2'd0;
	localparam logic [1:0] CLS_SMALL  = 2'd1;
	localparam logic [1:0] CLS_BYTE   = 2'd2;
	localparam logic [1:0] CLS_LIT    = 2'd3;

	// slot hash coefficients
	localparam logic [IDX_W-1:0] HASH_DIST  = IDX_W'(3);
	localparam logic [IDX_W-1:0] HASH_ALIGN = IDX_W'(5);
	localparam logic [IDX_W-1:0] HASH_MAT   = IDX_W'(7);

	// one decoded code, handed from the byte parser to the result stage
	typedef struct packed {
		logic                       emit;
		logic                       lit;
		logic [IDX_W-1:0]           addr;
		logic signed [DDIST_W-1:0]  ddist;
		logic signed [DALIGN_W-1:0] dalign;
		logic [LIT_DIST_W-1:0]      lit_dist;
		logic [LIT_ALIGN_W-1:0]     lit_align;
		logic [MAT_W-1:0]           lit_mat;
	} req_t;

	typedef struct packed {
		logic signed [DIST_W-1:0]  distance;
		logic signed [ALIGN_W-1:0] align;
		logic [MAT_W-1:0]          mat;
	} ray_t;

endpackage

// ===== src/rstd_decode.sv =====
module rstd_decode import rstd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] code_byte,
	input  logic       frame_start,
	output req_t       req
);

	typedef enum logic [4:0] {
		K_IDLE  = 5'b00001,
		K_SMALL = 5'b00010,
		K_BYTE  = 5'b00100,
		K_SHORT = 5'b01000,
		K_LONG  = 5'b10000
	} kind_t;

	kind_t      kind_q, kind_d, kind_eff;
	logic [1:0] seen_q, seen_d, seen_eff;
	logic [7:0] first_q, first_d;
	logic [7:0] second_q, second_d;
	logic [7:0] third_q, third_d;

	always_comb begin
		// a frame start drops any partial code
		kind_eff = frame_start ? K_IDLE : kind_q;
		seen_eff = frame_start ? 2'd0 : seen_q;
		kind_d   = kind_eff;
		seen_d   = seen_eff;
		first_d  = first_q;
		second_d = second_q;
		third_d  = third_q;
		req      = '0;
		req.addr = first_q[IDX_W-1:0];
		unique case (kind_eff)
			K_IDLE: begin
				if (code_byte[7:6] == CLS_DIRECT) begin
					req.emit = 1'b1;
					req.addr = code_byte[IDX_W-1:0];
				end else begin
					first_d = code_byte;
					seen_d  = 2'd1;
					priority if (code_byte[7:6] == CLS_SMALL)
						kind_d = K_SMALL;
					else if (code_byte[7:6] == CLS_BYTE)
						kind_d = K_BYTE;
					else if (code_byte == CODE_LONG)
						kind_d = K_LONG;
					else
						kind_d = K_SHORT;
				end
			end
			K_SMALL: begin
				req.emit   = 1'b1;
				req.ddist  = $signed({4'b0000, code_byte[7:3]}) - 9'sd15;
				req.dalign = $signed({1'b0, code_byte[2:0]}) - 4'sd3;
				kind_d     = K_IDLE;
				seen_d     = 2'd0;
			end
			K_BYTE: begin
				req.emit  = 1'b1;
				req.ddist = $signed({1'b0, code_byte}) - 9'sd127;
				kind_d    = K_IDLE;
				seen_d    = 2'd0;
			end
			K_SHORT: begin
				if (seen_eff == 2'd1) begin
					second_d = code_byte;
					seen_d   = 2'd2;
				end else begin
					req.emit      = 1'b1;
					req.lit       = 1'b1;
					req.lit_dist  = {second_q, code_byte[7:6]};
					req.lit_align = code_byte[LIT_ALIGN_W-1:0];
					req.lit_mat   = {2'b00, first_q[IDX_W-1:0]};
					kind_d        = K_IDLE;
					seen_d        = 2'd0;
				end
			end
			K_LONG: begin
				if (seen_eff == 2'd1) begin
					second_d = code_byte;
					seen_d   = 2'd2;
				end else if (seen_eff == 2'd2) begin
					third_d = code_byte;
					seen_d  = 2'd3;
				end else begin
					req.emit      = 1'b1;
					req.lit       = 1'b1;
					req.lit_dist  = {second_q, third_q[7:6]};
					req.lit_align = third_q[LIT_ALIGN_W-1:0];
					req.lit_mat   = code_byte;
					kind_d        = K_IDLE;
					seen_d        = 2'd0;
				end
			end
			default: begin
				kind_d = K_IDLE;
				seen_d = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= K_IDLE;
			seen_q <= 2'd0;
		end else if (accept) begin
			kind_q <= kind_d;
			seen_q <= seen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q  <= first_d;
			second_q <= second_d;
			third_q  <= third_d;
		end
	end

endmodule

// ===== src/rstd_table.sv =====
module rstd_table import rstd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_addr,
	input  logic               clr,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  logic [ENTRY_W-1:0] wr_data,
	output logic [ENTRY_W-1:0] rd_data
);

	logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [ENTRY_W-1:0]     rd_q;
	logic                   rd_vld_q;
	logic                   hit;

	assign hit = wr_en && (wr_addr == rd_addr);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// forward a write landing on the same edge as the read
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_q <= hit ? wr_data : mem[rd_addr];
	end

	// a clear belongs to the newer byte, so it wins over the older write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr)
				valid_q <= '0;
			else if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= !clr && (hit || valid_q[rd_addr]);
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ===== src/rstd_ray.sv =====
module rstd_ray import rstd_pkg::*; (
	input  req_t               req,
	input  logic [ENTRY_W-1:0] entry,
	output ray_t               ray,
	output logic [IDX_W-1:0]   slot,
	output logic [ENTRY_W-1:0] lit_entry
);

	logic [IDX_W-1:0] d6, a6, m6;

	always_comb begin
		d6   = IDX_W'(req.lit_dist[LIT_DIST_W-1:7]);
		a6   = IDX_W'(req.lit_align[LIT_ALIGN_W-1:4]);
		m6   = req.lit_mat[IDX_W-1:0];
		// all terms are taken mod the table depth
		slot = d6 * HASH_DIST + a6 * HASH_ALIGN + m6 * HASH_MAT;
		lit_entry = {req.lit_dist, {(ALIGN_W-LIT_ALIGN_W){1'b0}}, req.lit_align, req.lit_mat};
		if (req.lit) begin
			ray.distance = $signed({{(DIST_W-LIT_DIST_W){1'b0}}, req.lit_dist});
			ray.align    = $signed({{(ALIGN_W-LIT_ALIGN_W){1'b0}}, req.lit_align});
			ray.mat      = req.lit_mat;
		end else begin
			ray.distance = $signed({{(DIST_W-LIT_DIST_W){1'b0}}, entry[ENTRY_W-1 -: LIT_DIST_W]})
			             + {{(DIST_W-DDIST_W){req.ddist[DDIST_W-1]}}, req.ddist};
			ray.align    = $signed(entry[MAT_W +: ALIGN_W])
			             + {{(ALIGN_W-DALIGN_W){req.dalign[DALIGN_W-1]}}, req.dalign};
			ray.mat      = entry[MAT_W-1:0];
		end
	end

endmodule

// ===== src/ray_stream_table_decoder.sv =====
// Channel | Transaction                  | tdata (low bit up)                   | tuser
// s_*     | one byte of the ray stream   | [7:0] code_byte                      | frame_start
// m_*     | one decoded ray              | [11:0] ray_distance, [19:12]         | -
//         |                              | ray_alignment, [27:20] ray_material,  |
//         |                              | [31:28] zero                          |
// One byte is taken every cycle while m_tready is high. The byte that completes a code
// is registered in stage 1 with the table read, then in the result register driving m_*.
// Reset clears the parser, the table valid bits and both valid flags; the table needs no
// clearing pass. A frame start clears all valid bits at once.
// When m_tready is low the result register and the stage before it fill, then s_tready
// drops; bytes that complete no code still need a free slot in front of the stage.
module ray_stream_table_decoder import rstd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] code_byte
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [11:0] distance, [19:12] alignment, [27:20] material
);

	logic               accept;
	logic               adv_s1;
	logic               vld_s1;
	req_t               req;
	req_t               req_s1;
	logic [ENTRY_W-1:0] entry_s1;
	logic [ENTRY_W-1:0] lit_entry;
	logic [IDX_W-1:0]   slot;
	ray_t               ray;
	logic               m_tvalid_q;
	logic [31:0]        m_tdata_q;

	// take a byte whenever the stage ahead is empty or moving on this edge
	assign adv_s1   = vld_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !vld_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	// parse the byte against the held code state; table read is issued in the same edge
	rstd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.code_byte   (s_tdata),
		.frame_start (s_tuser),
		.req         (req)
	);

	// write literals back as they leave the stage
	rstd_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (req.addr),
		.clr     (accept && s_tuser),
		.wr_en   (adv_s1 && req_s1.lit),
		.wr_addr (slot),
		.wr_data (lit_entry),
		.rd_data (entry_s1)
	);

	rstd_ray u_ray (
		.req       (req_s1),
		.entry     (entry_s1),
		.ray       (ray),
		.slot      (slot),
		.lit_entry (lit_entry)
	);

	// stage 1: hold the decoded code; only codes that finish a ray enter it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= req.emit;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= req;
	end

	// result register: hold the ray until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			m_tdata_q <= {4'b0000, ray.mat, ray.align, ray.distance};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== src/rstd_chk.sv =====
module rstd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input only backs up when the output is stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// a new result follows an accepted byte through stage 1 and the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without a matching byte");

	// a direct reference on the frame start byte reads a cleared entry
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser && s_tdata[7:6] == 2'b00)
		##1 (!m_tvalid || m_tready) |=> m_tvalid && m_tdata == 32'd0)
		else $error("table entry not cleared by frame start");

endmodule

bind ray_stream_table_decoder rstd_chk u_rstd_chk (.*);
